// File: rtl/ssnt_pkg.sv
// shared types, sizes and op codes for the sorted sparse noise table
// no dependencies; used by the top level and ssnt_cmp
package ssnt_pkg;

  localparam int unsigned DEPTH   = 256;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W   = ADDR_W + 1;
  localparam int unsigned ID_BITS = 16;
  localparam int unsigned NZ_W    = 16;
  localparam int unsigned SUM_W   = 32;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic [NZ_W-1:0] NOISE_PER_UNIT_RST = NZ_W'(1024);

  // one stored entry, id in the upper bits
  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [NZ_W-1:0]    noise;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // status from the shared compare unit
  typedef struct packed {
    logic go_right;
    logic id_eq;
  } cmp_res_t;

endpackage

// File: rtl/sorted_sparse_noise_table.sv
// top level: sequencer, entry ram and output register of the noise table
// depends on ssnt_pkg, ssnt_ram and ssnt_cmp
//
// channel   dir  handshake               payload
// s_axis    in   tvalid/tready           tdata {membership, entry_id}, tuser {first, op}, tlast
// m_axis    out  tvalid/tready           tdata {entry_count, noise_sum, noise}, tuser {full, found}
// cfg       in   cfg_we_i                cfg_wdata_i = noise_per_unit
//
// clear, no-op and dropped inserts go straight to the output stage; a query runs a binary search
// of P probes (about log2(count+1)), each a ram read and a compare, then reads the entry at the
// stop point if it lies inside the table; an insert runs the same search, then moves the entries
// above the insert point up one place, all through the single ram read port; reset leaves the ram contents as they are
// s_axis_tready_o is high only while idle; a result waiting on m_axis does not block
// acceptance, only the final write of the next result
module sorted_sparse_noise_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // entry_id[15:0], membership[31:16]
  input  logic [2:0]  s_axis_tuser_i,   // op[1:0], first_query[2]
  input  logic        s_axis_tlast_i,   // last_query
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // noise[15:0], noise_sum[47:16], entry_count[56:48]
  output logic [1:0]  m_axis_tuser_o,   // found[0], table_full[1]
  output logic        m_axis_tlast_o    // run_done
);

  localparam int unsigned AW = ssnt_pkg::ADDR_W;
  localparam int unsigned CW = ssnt_pkg::CNT_W;
  localparam int unsigned NW = ssnt_pkg::NZ_W;
  localparam int unsigned SW = ssnt_pkg::SUM_W;

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_SRCH_RD  = 9'b000000010,
    ST_SRCH_CMP = 9'b000000100,
    ST_FIND_RD  = 9'b000001000,
    ST_FIND_CHK = 9'b000010000,
    ST_SHIFT_RD = 9'b000100000,
    ST_SHIFT_WR = 9'b001000000,
    ST_PUT      = 9'b010000000,
    ST_FIN      = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [NW-1:0]    npu_q;
  logic [1:0]       op_q, op_d;
  ssnt_pkg::entry_t key_q, key_d;
  logic             first_q, first_d;
  logic             last_q, last_d;
  logic [CW-1:0]    lo_q, lo_d;
  logic [CW-1:0]    hi_q, hi_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    count_q, count_d;
  logic [SW-1:0]    sum_q, sum_d;
  logic [NW-1:0]    res_noise_q, res_noise_d;
  logic             res_found_q, res_found_d;
  logic             res_full_q, res_full_d;

  logic             m_valid_q, m_valid_d;
  logic [NW-1:0]    out_noise_q, out_noise_d;
  logic             out_found_q, out_found_d;
  logic             out_full_q, out_full_d;
  logic             out_done_q, out_done_d;
  logic [SW-1:0]    out_sum_q, out_sum_d;
  logic [CW-1:0]    out_count_q, out_count_d;

  logic             in_beat;
  logic [CW-1:0]    mid;
  logic [NW-1:0]    in_id;
  logic [NW-1:0]    in_mem;
  logic [NW-1:0]    in_noise;
  logic [SW-1:0]    sum_base;
  logic [SW:0]      sum_ext;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  ssnt_pkg::entry_t              ram_wdata;
  logic [AW-1:0]                 ram_raddr;
  logic [ssnt_pkg::ENTRY_W-1:0]  ram_rdata;
  ssnt_pkg::entry_t              rd_entry;
  ssnt_pkg::cmp_res_t            cmp_res;

  assign in_beat         = s_axis_tvalid_i & s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_id           = s_axis_tdata_i[15:0];
  assign in_mem          = s_axis_tdata_i[31:16];
  assign in_noise        = (in_mem > npu_q) ? '0 : (npu_q - in_mem);
  assign mid             = lo_q + ((hi_q - lo_q) >> 1);
  assign rd_entry        = ssnt_pkg::entry_t'(ram_rdata);

  // saturating running sum
  assign sum_base = first_q ? '0 : sum_q;
  assign sum_ext  = {1'b0, sum_base} + (SW + 1)'(res_noise_q);

  // entry store
  ssnt_ram #(
    .WIDTH (ssnt_pkg::ENTRY_W),
    .DEPTH (ssnt_pkg::DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  // shared compare
  ssnt_cmp u_cmp (
    .entry_i     (rd_entry),
    .key_i       (key_q),
    .tie_noise_i (op_q == ssnt_pkg::OP_INSERT),
    .res_o       (cmp_res)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    first_d     = first_q;
    last_d      = last_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    idx_d       = idx_q;
    count_d     = count_q;
    sum_d       = sum_q;
    res_noise_d = res_noise_q;
    res_found_d = res_found_q;
    res_full_d  = res_full_q;
    m_valid_d   = m_valid_q & ~m_axis_tready_i;
    out_noise_d = out_noise_q;
    out_found_d = out_found_q;
    out_full_d  = out_full_q;
    out_done_d  = out_done_q;
    out_sum_d   = out_sum_q;
    out_count_d = out_count_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q[AW-1:0];
    ram_wdata   = rd_entry;
    ram_raddr   = mid[AW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          op_d        = s_axis_tuser_i[1:0];
          first_d     = s_axis_tuser_i[2];
          last_d      = s_axis_tlast_i;
          key_d.id    = in_id[ssnt_pkg::ID_BITS-1:0];
          key_d.noise = in_noise;
          lo_d        = '0;
          hi_d        = count_q;
          res_found_d = 1'b0;
          res_full_d  = 1'b0;
          res_noise_d = '0;
          case (s_axis_tuser_i[1:0])
            ssnt_pkg::OP_INSERT: begin
              res_noise_d = in_noise;
              if (count_q == CW'(ssnt_pkg::DEPTH)) begin
                res_full_d = 1'b1;
                state_d    = ST_FIN;
              end else begin
                state_d = ST_SRCH_RD;
              end
            end
            ssnt_pkg::OP_QUERY: state_d = ST_SRCH_RD;
            default:            state_d = ST_FIN;
          endcase
        end
      end
      ST_SRCH_RD: begin
        if (lo_q < hi_q) begin
          state_d = ST_SRCH_CMP;
        end else if (op_q == ssnt_pkg::OP_INSERT) begin
          idx_d   = count_q;
          state_d = ST_SHIFT_RD;
        end else begin
          state_d = ST_FIND_RD;
        end
      end
      ST_SRCH_CMP: begin
        if (cmp_res.go_right) begin
          lo_d = mid + CW'(1);
        end else begin
          hi_d = mid;
        end
        state_d = ST_SRCH_RD;
      end
      ST_FIND_RD: begin
        ram_raddr = lo_q[AW-1:0];
        if (lo_q < count_q) begin
          state_d = ST_FIND_CHK;
        end else begin
          res_noise_d = npu_q;
          state_d     = ST_FIN;
        end
      end
      ST_FIND_CHK: begin
        res_found_d = cmp_res.id_eq;
        res_noise_d = cmp_res.id_eq ? rd_entry.noise : npu_q;
        state_d     = ST_FIN;
      end
      // move entries up one place, from the top down to the insert point
      ST_SHIFT_RD: begin
        ram_raddr = idx_q[AW-1:0] - AW'(1);
        if (idx_q > lo_q) begin
          state_d = ST_SHIFT_WR;
        end else begin
          state_d = ST_PUT;
        end
      end
      ST_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        ram_wdata = rd_entry;
        idx_d     = idx_q - CW'(1);
        state_d   = ST_SHIFT_RD;
      end
      ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = lo_q[AW-1:0];
        ram_wdata = key_q;
        count_d   = count_q + CW'(1);
        state_d   = ST_FIN;
      end
      // load the output register once it is free
      ST_FIN: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d   = 1'b1;
          out_noise_d = res_noise_q;
          out_found_d = res_found_q;
          out_full_d  = res_full_q;
          out_done_d  = (op_q == ssnt_pkg::OP_QUERY) & last_q;
          out_sum_d   = sum_q;
          out_count_d = count_q;
          if (op_q == ssnt_pkg::OP_QUERY) begin
            sum_d     = sum_ext[SW] ? '1 : sum_ext[SW-1:0];
            out_sum_d = sum_d;
          end
          if (op_q == ssnt_pkg::OP_CLEAR) begin
            count_d     = '0;
            out_count_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      npu_q     <= ssnt_pkg::NOISE_PER_UNIT_RST;
      count_q   <= '0;
      sum_q     <= '0;
      m_valid_q <= 1'b0;
      lo_q      <= '0;
      hi_q      <= '0;
      idx_q     <= '0;
      op_q      <= ssnt_pkg::OP_NOP;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      sum_q     <= sum_d;
      m_valid_q <= m_valid_d;
      lo_q      <= lo_d;
      hi_q      <= hi_d;
      idx_q     <= idx_d;
      op_q      <= op_d;
      if (cfg_we_i) begin
        npu_q <= cfg_wdata_i;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    first_q     <= first_d;
    last_q      <= last_d;
    res_noise_q <= res_noise_d;
    res_found_q <= res_found_d;
    res_full_q  <= res_full_d;
    out_noise_q <= out_noise_d;
    out_found_q <= out_found_d;
    out_full_q  <= out_full_d;
    out_done_q  <= out_done_d;
    out_sum_q   <= out_sum_d;
    out_count_q <= out_count_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_count_q, out_sum_q, out_noise_q};
  assign m_axis_tuser_o  = {out_full_q, out_found_q};
  assign m_axis_tlast_o  = out_done_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(ssnt_pkg::DEPTH))
    else $error("entry count above table depth");

  a_search_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SRCH_CMP) |-> (lo_q < hi_q) && (hi_q <= count_q))
    else $error("search window out of range");

  a_shift_above_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT_WR) |-> (idx_q > lo_q) && (idx_q < CW'(ssnt_pkg::DEPTH)))
    else $error("entry move outside insert range");

  a_full_means_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && out_full_q) |-> (out_count_q == CW'(ssnt_pkg::DEPTH)))
    else $error("dropped insert reported with room left");
`endif

endmodule

// File: rtl/ssnt_ram.sv
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
module ssnt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/ssnt_cmp.sv
// shared compare unit for the binary search and the final id check
// depends on ssnt_pkg
module ssnt_cmp (
  input  ssnt_pkg::entry_t   entry_i,
  input  ssnt_pkg::entry_t   key_i,
  input  logic               tie_noise_i,
  output ssnt_pkg::cmp_res_t res_o
);

  logic id_lt;
  logic id_eq;
  logic nz_le;

  assign id_lt = entry_i.id < key_i.id;
  assign id_eq = entry_i.id == key_i.id;
  assign nz_le = entry_i.noise <= key_i.noise;

  // insert search also orders equal ids by noise
  always_comb begin
    res_o.id_eq    = id_eq;
    res_o.go_right = id_lt | (tie_noise_i & id_eq & nz_le);
  end

endmodule

// File: tb/sv/tb_sorted_sparse_noise_table.sv
// self-checking testbench for the sorted sparse noise table
// depends on ssnt_pkg and sorted_sparse_noise_table; drives both stream ports
`timescale 1ns / 1ps

module tb_sorted_sparse_noise_table;

  // one result beat, split into its fields
  typedef struct packed {
    logic [15:0] noise;
    logic        found;
    logic [31:0] sum;
    logic [8:0]  cnt;
    logic        full;
    logic        done;
  } noise_beat_t;

  // one row of the directed part
  typedef struct {
    logic [1:0]  op;
    logic [15:0] id;
    logic [15:0] mem;
    logic        first;
    logic        last;
    bit          typed;
    noise_beat_t want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_valid = 1'b0;
  logic [31:0] s_data = '0;
  logic [2:0]  s_user = '0;
  logic        s_last = 1'b0;
  logic        m_ready = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic [63:0] m_data;
  logic [1:0]  m_user;
  logic        m_last;

  // mirror of the table contents and registers
  logic [15:0] tbl_id [ssnt_pkg::DEPTH];
  logic [15:0] tbl_nz [ssnt_pkg::DEPTH];
  int          tbl_cnt = 0;
  logic [31:0] sum_acc = '0;
  logic [15:0] unit_noise = ssnt_pkg::NOISE_PER_UNIT_RST;

  noise_beat_t noise_beats_due [$];
  stim_row_t   directed [$];
  int          mismatch_count = 0;
  bit          no_idle = 1'b0;

  sorted_sparse_noise_table u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // hard stop if the table hangs
  initial begin
    #100_000_000;
    $display("** sorted_sparse_noise_table: FAILED **");
    $finish;
  end

  function automatic int draw_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s: got 0x%0h, expected 0x%0h", field, got, want);
    mismatch_count++;
  endtask

  // expected beat for one accepted item, updates the mirror
  function automatic noise_beat_t predict_noise_beat(input logic [1:0] op,
      input logic [15:0] id, input logic [15:0] mem, input logic first, input logic last);
    noise_beat_t b;
    int          pos;
    logic [32:0] acc;
    b = '0;
    case (op)
      ssnt_pkg::OP_CLEAR: tbl_cnt = 0;
      ssnt_pkg::OP_INSERT: begin
        b.noise = (mem > unit_noise) ? 16'd0 : unit_noise - mem;
        if (tbl_cnt >= ssnt_pkg::DEPTH) begin
          b.full = 1'b1;
        end else begin
          // place after every entry with a smaller id, or equal id and noise
          pos = 0;
          while (pos < tbl_cnt && (tbl_id[pos] < id ||
                 (tbl_id[pos] == id && tbl_nz[pos] <= b.noise)))
            pos++;
          for (int i = tbl_cnt; i > pos; i--) begin
            tbl_id[i] = tbl_id[i-1];
            tbl_nz[i] = tbl_nz[i-1];
          end
          tbl_id[pos] = id;
          tbl_nz[pos] = b.noise;
          tbl_cnt++;
        end
      end
      ssnt_pkg::OP_QUERY: begin
        pos = 0;
        while (pos < tbl_cnt && tbl_id[pos] < id) pos++;
        if (pos < tbl_cnt && tbl_id[pos] == id) begin
          b.noise = tbl_nz[pos];
          b.found = 1'b1;
        end else begin
          b.noise = unit_noise;
        end
        if (first) sum_acc = '0;
        // saturating add
        acc = {1'b0, sum_acc} + 33'(b.noise);
        sum_acc = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
        b.done = last;
      end
      default: ;
    endcase
    b.sum = sum_acc;
    b.cnt = 9'(tbl_cnt);
    return b;
  endfunction

  // push one beat on the slave side and record what it should produce
  task automatic send_beat(input logic [1:0] op, input logic [15:0] id,
      input logic [15:0] mem, input logic first, input logic last,
      input bit typed, input noise_beat_t want);
    int          gap;
    noise_beat_t pred;
    gap = draw_gap();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {mem, id};
    s_user  <= {first, op};
    s_last  <= last;
    do @(posedge clk_i); while (s_ready !== 1'b1);
    pred = predict_noise_beat(op, id, mem, first, last);
    noise_beats_due.insert(noise_beats_due.size(), typed ? want : pred);
  endtask

  task automatic send(input logic [1:0] op, input logic [15:0] id,
      input logic [15:0] mem, input logic first, input logic last);
    send_beat(op, id, mem, first, last, 1'b0, '0);
  endtask

  // stop sending until every result is back
  task automatic hold_until_drained();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (noise_beats_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_noise_unit(input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    unit_noise = v;
  endtask

  function automatic void add_row(input logic [1:0] op, input logic [15:0] id,
      input logic [15:0] mem, input logic first, input logic last, input bit typed,
      input logic [15:0] nz, input logic [31:0] sum, input logic [8:0] cnt);
    stim_row_t r;
    r.op = op;
    r.id = id;
    r.mem = mem;
    r.first = first;
    r.last = last;
    r.typed = typed;
    r.want = '{noise: nz, found: 1'b0, sum: sum, cnt: cnt, full: 1'b0,
               done: (op == ssnt_pkg::OP_QUERY) ? last : 1'b0};
    directed.insert(directed.size(), r);
  endfunction

  // mostly small ids and ids already held, so queries hit
  function automatic logic [15:0] pick_id();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    if (r <= 5) return 16'($urandom_range(0, 31));
    if (r <= 7 && tbl_cnt > 0) return tbl_id[$urandom_range(0, tbl_cnt - 1)];
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_mem();
    int r;
    r = $urandom_range(0, 7);
    case (r)
      0: return 16'h0000;
      1: return unit_noise;
      2: return (unit_noise == 16'hFFFF) ? 16'hFFFF : unit_noise + 16'd1;
      3: return 16'hFFFF;
      4, 5: return 16'($urandom_range(0, unit_noise));
      default: return 16'($urandom);
    endcase
  endfunction

  // master side: random stalls, compare each beat with the oldest expectation
  initial begin
    int          stall;
    noise_beat_t got;
    noise_beat_t want;
    do @(posedge clk_i); while (rst_ni !== 1'b1);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (m_valid !== 1'b1);
      got.noise = m_data[15:0];
      got.sum   = m_data[47:16];
      got.cnt   = m_data[56:48];
      got.found = m_user[0];
      got.full  = m_user[1];
      got.done  = m_last;
      if (noise_beats_due.size() == 0) begin
        report_mismatch("beat with nothing due, noise", 32'(got.noise), 32'h0);
      end else begin
        want = noise_beats_due.pop_front();
        if (got.noise !== want.noise) report_mismatch("noise", 32'(got.noise), 32'(want.noise));
        if (got.found !== want.found) report_mismatch("found", 32'(got.found), 32'(want.found));
        if (got.sum !== want.sum) report_mismatch("noise_sum", got.sum, want.sum);
        if (got.cnt !== want.cnt) report_mismatch("entry_count", 32'(got.cnt), 32'(want.cnt));
        if (got.full !== want.full) report_mismatch("table_full", 32'(got.full), 32'(want.full));
        if (got.done !== want.done) report_mismatch("run_done", 32'(got.done), 32'(want.done));
      end
    end
  end

  // stimulus
  initial begin
    logic [15:0] units [4];
    int          sent;
    int          n;

    // directed rows, typed where obvious from reset values
    add_row(ssnt_pkg::OP_QUERY, 16'd0, 16'd0, 1'b1, 1'b0, 1, 16'd1024, 32'd1024, 9'd0);
    add_row(ssnt_pkg::OP_QUERY, 16'hFFFF, 16'd0, 1'b0, 1'b1, 1, 16'd1024, 32'd2048, 9'd0);
    add_row(ssnt_pkg::OP_NOP, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1, 16'd0, 32'd2048, 9'd0);
    add_row(ssnt_pkg::OP_CLEAR, 16'd0, 16'd0, 1'b0, 1'b0, 1, 16'd0, 32'd2048, 9'd0);
    add_row(ssnt_pkg::OP_INSERT, 16'd100, 16'd0, 1'b0, 1'b0, 1, 16'd1024, 32'd2048, 9'd1);
    add_row(ssnt_pkg::OP_INSERT, 16'd100, 16'd1024, 1'b0, 1'b0, 1, 16'd0, 32'd2048, 9'd2);
    // membership above the unit saturates to zero
    add_row(ssnt_pkg::OP_INSERT, 16'd100, 16'hFFFF, 1'b0, 1'b0, 1, 16'd0, 32'd2048, 9'd3);
    add_row(ssnt_pkg::OP_INSERT, 16'd0, 16'd24, 1'b0, 1'b0, 1, 16'd1000, 32'd2048, 9'd4);
    add_row(ssnt_pkg::OP_INSERT, 16'hFFFF, 16'd1, 1'b0, 1'b0, 1, 16'd1023, 32'd2048, 9'd5);
    add_row(ssnt_pkg::OP_INSERT, 16'd100, 16'd1000, 1'b0, 1'b0, 0, 16'd0, 32'd0, 9'd0);
    // duplicate id returns its smallest noise
    add_row(ssnt_pkg::OP_QUERY, 16'd100, 16'd0, 1'b1, 1'b0, 0, 16'd0, 32'd0, 9'd0);
    add_row(ssnt_pkg::OP_QUERY, 16'd0, 16'hFFFF, 1'b0, 1'b0, 0, 16'd0, 32'd0, 9'd0);
    add_row(ssnt_pkg::OP_QUERY, 16'hFFFF, 16'd0, 1'b0, 1'b0, 0, 16'd0, 32'd0, 9'd0);
    add_row(ssnt_pkg::OP_QUERY, 16'd99, 16'd0, 1'b0, 1'b0, 0, 16'd0, 32'd0, 9'd0);
    add_row(ssnt_pkg::OP_QUERY, 16'd101, 16'd0, 1'b0, 1'b0, 0, 16'd0, 32'd0, 9'd0);
    add_row(ssnt_pkg::OP_QUERY, 16'hFFFE, 16'd0, 1'b0, 1'b1, 0, 16'd0, 32'd0, 9'd0);
    add_row(ssnt_pkg::OP_INSERT, 16'd50, 16'd0, 1'b1, 1'b1, 0, 16'd0, 32'd0, 9'd0);
    add_row(ssnt_pkg::OP_QUERY, 16'd50, 16'd0, 1'b0, 1'b0, 0, 16'd0, 32'd0, 9'd0);
    add_row(ssnt_pkg::OP_NOP, 16'd50, 16'h5555, 1'b1, 1'b0, 0, 16'd0, 32'd0, 9'd0);
    // clear keeps the running sum
    add_row(ssnt_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 0, 16'd0, 32'd0, 9'd0);
    add_row(ssnt_pkg::OP_QUERY, 16'd100, 16'd0, 1'b0, 1'b1, 0, 16'd0, 32'd0, 9'd0);
    add_row(ssnt_pkg::OP_QUERY, 16'd100, 16'd0, 1'b1, 1'b1, 0, 16'd0, 32'd0, 9'd0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i])
      send_beat(directed[i].op, directed[i].id, directed[i].mem, directed[i].first,
                directed[i].last, directed[i].typed, directed[i].want);

    // fill the table past full, then look around in it
    hold_until_drained();
    set_noise_unit(16'd40000);
    send(ssnt_pkg::OP_CLEAR, 16'd0, 16'd0, 1'b0, 1'b0);
    for (int k = 0; k < ssnt_pkg::DEPTH + 3; k++)
      send(ssnt_pkg::OP_INSERT, 16'($urandom_range(0, 511)), 16'($urandom), 1'b0, 1'b0);
    for (int k = 0; k < 12; k++)
      send(ssnt_pkg::OP_QUERY, pick_id(), 16'($urandom), k == 0, k == 11);
    send(ssnt_pkg::OP_CLEAR, 16'd0, 16'd0, 1'b0, 1'b0);

    // random phases, one unit setting each
    units[0] = 16'd1;
    units[1] = 16'hFFFF;
    units[2] = 16'($urandom_range(1, 65535));
    units[3] = ssnt_pkg::NOISE_PER_UNIT_RST;
    foreach (units[u]) begin
      hold_until_drained();
      set_noise_unit(units[u]);
      sent = 0;
      while (sent < 430) begin
        if ($urandom_range(0, 4) != 0) begin
          // optional clear, then inserts followed by one well-formed query run
          if (tbl_cnt > 40 || $urandom_range(0, 3) == 0) begin
            send(ssnt_pkg::OP_CLEAR, pick_id(), pick_mem(), 1'($urandom), 1'($urandom));
            sent++;
          end
          n = $urandom_range(0, 12);
          repeat (n) begin
            send(ssnt_pkg::OP_INSERT, pick_id(), pick_mem(), 1'($urandom), 1'($urandom));
            sent++;
          end
          n = $urandom_range(1, 8);
          for (int k = 0; k < n; k++) begin
            send(ssnt_pkg::OP_QUERY, pick_id(), 16'($urandom), k == 0, k == n - 1);
            sent++;
          end
        end else begin
          // noise: any op, any flags, broken runs
          n = $urandom_range(1, 5);
          repeat (n) begin
            send(2'($urandom_range(0, 3)), pick_id(), pick_mem(),
                 1'($urandom), 1'($urandom));
            sent++;
          end
        end
        if ($urandom_range(0, 19) == 0) hold_until_drained();
        if ($urandom_range(0, 14) == 0) no_idle = !no_idle;
      end
      no_idle = 1'b0;
    end

    // back-to-back queries with the widest unit
    hold_until_drained();
    set_noise_unit(16'hFFFF);
    no_idle = 1'b1;
    send(ssnt_pkg::OP_CLEAR, 16'd0, 16'd0, 1'b0, 1'b0);
    for (int k = 0; k < 40; k++)
      send(ssnt_pkg::OP_QUERY, 16'h1234, 16'd0, k == 0, k == 39);
    no_idle = 1'b0;
    send(ssnt_pkg::OP_QUERY, 16'h1234, 16'd0, 1'b1, 1'b1);

    hold_until_drained();
    repeat (600) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("** sorted_sparse_noise_table: PASSED **");
    end else begin
      $display("** sorted_sparse_noise_table: FAILED **");
    end
    $finish;
  end

endmodule
